// ----- rtl/dna2p_pkg.sv -----
// Shared definitions for the 2-bit packed base store.
// Item mode codes, result status codes and the per-lane read descriptor.
// No dependencies.
`timescale 1ns / 1ps

package dna2p_pkg;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int LANES = 4;

    // One image position of a packed byte: which bank feeds it, whether it
    // is complemented, and whether it lies inside the image.
    typedef struct packed {
        logic [1:0] bank;
        logic       comp;
        logic       live;
    } lane_t;

endpackage

// ----- rtl/dna2p_bank.sv -----
// One bank of the base store: synchronous RAM, one write and one read port.
// Read data is registered. Depends on nothing.
`timescale 1ns / 1ps

module dna2p_bank #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dna2p_decode.sv -----
// Read address decode: maps the four image positions of a packed byte onto
// store rows and banks. Uses dna2p_pkg (lane_t).
`timescale 1ns / 1ps

module dna2p_decode #(
    parameter int CW  = 17,
    parameter int PW  = 18,
    parameter int BAW = 14
) (
    input  logic [CW-1:0]                        fwd_len,
    input  logic                                 rev,
    input  logic                                 is_read,
    input  logic [14:0]                          byte_index,
    output logic [dna2p_pkg::LANES-1:0][BAW-1:0] bank_addr,
    output dna2p_pkg::lane_t [dna2p_pkg::LANES-1:0] lanes,
    output logic                                 in_range
);

    logic [PW-1:0] fwd;
    logic [PW-1:0] total;
    logic [PW-1:0] start;
    logic [PW-1:0] rev_top;
    logic [dna2p_pkg::LANES-1:0][BAW-1:0] row;

    assign fwd      = PW'(fwd_len);
    assign total    = rev ? (fwd << 1) : fwd;
    assign start    = PW'({byte_index, 2'b00});
    assign rev_top  = (fwd << 1) - PW'(1);
    assign in_range = start < total;

    always_comb
    begin
        logic [PW-1:0] p;
        logic [PW-1:0] a;
        for (int k = 0; k < dna2p_pkg::LANES; k++)
        begin
            p             = start + PW'(k);
            lanes[k].live = is_read && (p < total);
            lanes[k].comp = p >= fwd;
            a             = lanes[k].comp ? (rev_top - p) : p;
            lanes[k].bank = a[1:0];
            row[k]        = a[BAW+1:2];
        end
    end

    // Needed addresses sit in a window of four, so each bank sees one row.
    always_comb
    begin
        for (int b = 0; b < dna2p_pkg::LANES; b++)
        begin
            bank_addr[b] = '0;
            for (int k = dna2p_pkg::LANES - 1; k >= 0; k--)
            begin
                if (lanes[k].live && (lanes[k].bank == 2'(b)))
                begin
                    bank_addr[b] = row[k];
                end
            end
        end
    end

endmodule

// ----- rtl/dna_2bit_packer_revcomp.sv -----
// Top level of the 2-bit packed base store with reverse-complement image.
// Uses dna2p_pkg, dna2p_decode and four dna2p_bank instances.
//
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_data (append_reverse)
// in        in         in_valid/in_stall    mode, base, byte_index
// out       out        out_valid/out_stall  packed_byte, status, stored_count
//
// One item per cycle sustained while the output is not stalled; each result
// passes through the registered read of the four store banks and the
// output register. Reset clears the length, the pipeline and sets
// append_reverse; store contents are left as they are.
// A stalled output holds the whole pipeline and stalls the input channel.
`timescale 1ns / 1ps

module dna_2bit_packer_revcomp #(
    parameter int MAX_BASES = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic [1:0]                        base,
    input  logic [14:0]                       byte_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        packed_byte,
    output logic [1:0]                        status,
    output logic [$clog2(MAX_BASES + 1)-1:0]  stored_count
);

    localparam int CW      = $clog2(MAX_BASES + 1);
    localparam int PW      = (CW + 1 > 18) ? CW + 1 : 18;
    localparam int DEPTH_B = (MAX_BASES + 3) / 4;
    localparam int BAW     = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
    localparam int LANES   = dna2p_pkg::LANES;

    logic [CW-1:0] fwd_len_reg;
    logic [CW-1:0] fwd_len_next;
    logic          append_reverse_reg;

    logic                    s1_valid_reg;
    dna2p_pkg::lane_t [LANES-1:0] s1_lanes_reg;
    logic [1:0]              s1_status_reg;
    logic [CW-1:0]           s1_count_reg;

    logic                    out_valid_reg;
    logic [7:0]              packed_byte_reg;
    logic [7:0]              packed_byte_next;
    logic [1:0]              status_reg;
    logic [CW-1:0]           count_reg;

    logic advance;
    logic in_fire;
    logic is_append;
    logic is_read;
    logic is_clear;
    logic full;
    logic in_range;
    logic [1:0]    s0_status;
    logic [CW-1:0] s0_count;

    logic [LANES-1:0][BAW-1:0] bank_addr;
    dna2p_pkg::lane_t [LANES-1:0] lanes;
    logic [LANES-1:0]          wr_en;
    logic [1:0]                rd_data [LANES];

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign in_fire   = in_valid && advance;
    assign cfg_ready = 1'b1;

    assign is_append = mode == dna2p_pkg::MODE_APPEND;
    assign is_read   = mode == dna2p_pkg::MODE_READ;
    assign is_clear  = mode == dna2p_pkg::MODE_CLEAR;
    assign full      = fwd_len_reg == CW'(MAX_BASES);

    dna2p_decode #(
        .CW  (CW),
        .PW  (PW),
        .BAW (BAW)
    ) u_decode (
        .fwd_len    (fwd_len_reg),
        .rev        (append_reverse_reg),
        .is_read    (is_read),
        .byte_index (byte_index),
        .bank_addr  (bank_addr),
        .lanes      (lanes),
        .in_range   (in_range)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_bank
        assign wr_en[g] = in_fire && is_append && !full && (fwd_len_reg[1:0] == 2'(g));

        dna2p_bank #(
            .DEPTH (DEPTH_B),
            .AW    (BAW)
        ) u_bank (
            .clk   (clk),
            .we    (wr_en[g]),
            .waddr (fwd_len_reg[BAW+1:2]),
            .wdata (base),
            .re    (advance),
            .raddr (bank_addr[g]),
            .rdata (rd_data[g])
        );
    end

    always_comb
    begin
        s0_status    = dna2p_pkg::ST_OK;
        fwd_len_next = fwd_len_reg;
        if (is_append)
        begin
            if (full)
            begin
                s0_status = dna2p_pkg::ST_FULL;
            end
            else
            begin
                fwd_len_next = fwd_len_reg + CW'(1);
            end
        end
        else if (is_read)
        begin
            if (!in_range)
            begin
                s0_status = dna2p_pkg::ST_RANGE;
            end
        end
        else if (is_clear)
        begin
            fwd_len_next = '0;
        end
        s0_count = fwd_len_next;
    end

    always_comb
    begin
        logic [1:0] d;
        logic [1:0] c;
        packed_byte_next = '0;
        for (int k = 0; k < LANES; k++)
        begin
            d = rd_data[s1_lanes_reg[k].bank];
            c = s1_lanes_reg[k].comp ? (2'd3 - d) : d;
            packed_byte_next[7 - 2 * k -: 2] = s1_lanes_reg[k].live ? c : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_len_reg        <= '0;
            append_reverse_reg <= 1'b1;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                append_reverse_reg <= cfg_data;
            end
            if (in_fire)
            begin
                fwd_len_reg <= fwd_len_next;
            end
            if (advance)
            begin
                s1_valid_reg  <= in_valid;
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_lanes_reg    <= lanes;
            s1_status_reg   <= s0_status;
            s1_count_reg    <= s0_count;
            packed_byte_reg <= packed_byte_next;
            status_reg      <= s1_status_reg;
            count_reg       <= s1_count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign packed_byte  = packed_byte_reg;
    assign status       = status_reg;
    assign stored_count = count_reg;

endmodule

// ----- rtl/dna2p_checker.sv -----
// Port-level checks for dna_2bit_packer_revcomp, bound to the top level.
// Uses dna2p_pkg status codes.
`timescale 1ns / 1ps

module dna2p_checker #(
    parameter int MAX_BASES = 65536
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              in_stall,
    input logic [7:0]                        packed_byte,
    input logic [1:0]                        status,
    input logic [$clog2(MAX_BASES + 1)-1:0]  stored_count
);

    localparam int CW = $clog2(MAX_BASES + 1);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stored_count <= CW'(MAX_BASES))
        else $error("stored_count beyond capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == dna2p_pkg::ST_FULL) |-> stored_count == CW'(MAX_BASES))
        else $error("full status with spare capacity");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != dna2p_pkg::ST_OK) |-> packed_byte == 8'd0)
        else $error("nonzero byte on error status");

    a_stall_propagates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output blocked");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(packed_byte) && $stable(status)))
        else $error("stalled transaction changed");

endmodule

bind dna_2bit_packer_revcomp dna2p_checker #(
    .MAX_BASES (MAX_BASES)
) u_dna2p_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .packed_byte  (packed_byte),
    .status       (status),
    .stored_count (stored_count)
);
